// ----- design/pinhole_camera_projection_unit_defines.svh -----
// Assertion macros for the pinhole camera projection unit
`ifndef PINHOLE_CAMERA_PROJECTION_UNIT_DEFINES_SVH
`define PINHOLE_CAMERA_PROJECTION_UNIT_DEFINES_SVH

// same-cycle implication
`define PCP_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("pcp: same-cycle check failed");

// next-cycle implication
`define PCP_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("pcp: next-cycle check failed");

`endif

// ----- design/pcp_pkg.sv -----
// Shared types, widths and constants of the projection unit
package pcp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int PIXEL_BITS = 12;

  localparam int VAL_W     = 32;
  localparam int COORD_W   = 12;
  localparam int REG_W     = 64;
  localparam int NUM_REGS  = 6;
  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;

  // pixel minus principal point, signed
  localparam int DC_W  = ((COORD_W + FRAC_BITS + 1 > VAL_W) ?
                          COORD_W + FRAC_BITS + 1 : VAL_W) + 1;
  localparam int P0_W  = VAL_W + DC_W;
  localparam int PR_W  = 2 * VAL_W;
  localparam int H_W   = PR_W + 2;
  localparam int NUM_W = H_W + FRAC_BITS;
  localparam int DEN_W = H_W;
  localparam int NM_W  = NUM_W;
  localparam int DM_W  = DEN_W;
  // quotient bits kept; anything larger is flagged as overflow
  localparam int QB    = ((PIXEL_BITS + FRAC_BITS + 1 > VAL_W) ?
                          PIXEL_BITS + FRAC_BITS + 1 : VAL_W) + 1;
  localparam int QS_W  = QB + 2;
  localparam int CW    = DM_W + QB;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // coefficient slots (4*row + col)
  localparam int CF_FOCAL = 0;
  localparam int CF_PPX   = 2;
  localparam int CF_PPY   = 6;

  localparam logic OP_BACKPROJ = 1'b0;
  localparam logic OP_PROJECT  = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0_LEFT  = 3'd0,
    REG_ROW0_RIGHT = 3'd1,
    REG_ROW1_LEFT  = 3'd2,
    REG_ROW1_RIGHT = 3'd3,
    REG_ROW2_LEFT  = 3'd4,
    REG_ROW2_RIGHT = 3'd5
  } reg_idx_t;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef val_t [11:0] coef_t;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    val_t               depth;
    val_t               in_x;
    val_t               in_y;
    val_t               in_z;
  } in_item_t;

  typedef struct packed {
    val_t                  out_x;
    val_t                  out_y;
    val_t                  out_z;
    val_t                  plane_col;
    val_t                  plane_row;
    logic [PIXEL_BITS-1:0] round_col;
    logic [PIXEL_BITS-1:0] round_row;
    logic                  div_fault;
  } out_item_t;

  typedef struct packed {
    logic                   op;
    logic                   f_zero;
    val_t                   depth;
    val_t                   in_x;
    val_t                   in_y;
    val_t                   in_z;
    logic signed [DC_W-1:0] dc;
    logic signed [DC_W-1:0] dr;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic op;
    logic fault;
    val_t z;
  } side_t;

  typedef struct packed {
    logic [NM_W-1:0] rem;
    logic [QB-1:0]   quo;
    logic            neg;
    logic            ovf;
  } lane_t;

  typedef struct packed {
    logic            vld;
    side_t           side;
    lane_t           col;
    lane_t           row;
    logic [DM_W-1:0] den;
  } div_stage_t;

endpackage

// ----- design/pcp_if.sv -----
// Request and result channel interfaces
interface pcp_in_if import pcp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pcp_out_if import pcp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/pcp_queue.sv -----
// Short request queue between front and back
module pcp_queue import pcp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qitem_t  wdata,
  input  logic    pop,
  output qitem_t  rdata,
  output q_stat_t stat
);

  qitem_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rp_r];
  assign stat.full  = (cnt_r == QCW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ----- design/pcp_front.sv -----
// Front end: takes requests, checks the op, forms pixel offsets
module pcp_front import pcp_pkg::*; (
  pcp_in_if.sink  in_ch,
  input  coef_t   coef,
  input  q_stat_t q_stat,
  output logic    push,
  output qitem_t  item
);

  logic [COORD_W+FRAC_BITS:0] col_q;
  logic [COORD_W+FRAC_BITS:0] row_q;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    col_q       = {1'b0, in_ch.data.pixel_col, {FRAC_BITS{1'b0}}};
    row_q       = {1'b0, in_ch.data.pixel_row, {FRAC_BITS{1'b0}}};
    item.op     = in_ch.data.op;
    item.f_zero = (coef[CF_FOCAL] == '0);
    item.depth  = in_ch.data.depth;
    item.in_x   = in_ch.data.in_x;
    item.in_y   = in_ch.data.in_y;
    item.in_z   = in_ch.data.in_z;
    if (in_ch.data.op == OP_BACKPROJ) begin
      item.dc = DC_W'($signed(col_q)) - DC_W'($signed(coef[CF_PPX]));
      item.dr = DC_W'($signed(row_q)) - DC_W'($signed(coef[CF_PPY]));
    end else begin
      item.dc = '0;
      item.dr = '0;
    end
  end

endmodule

// ----- design/pcp_div.sv -----
// Pipelined restoring divider, two lanes sharing one divisor
module pcp_div import pcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  div_stage_t din,
  output div_stage_t dout
);

  div_stage_t st_r [QB+1];
  div_stage_t st0_nxt;

  function automatic lane_t lane_step(lane_t l, logic [DM_W-1:0] den, int unsigned sh);
    logic [CW-1:0] rw;
    logic [CW-1:0] dw;
    lane_t         o;
    o  = l;
    rw = CW'(l.rem);
    dw = CW'(den) << sh;
    if (rw >= dw) begin
      o.rem = NM_W'(rw - dw);
      o.quo = l.quo | (QB'(1) << sh);
    end
    return o;
  endfunction

  // quotient too wide for the kept bits
  always_comb begin
    st0_nxt         = din;
    st0_nxt.col.ovf = (CW'(din.col.rem) >= (CW'(din.den) << QB));
    st0_nxt.row.ovf = (CW'(din.row.rem) >= (CW'(din.den) << QB));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].vld <= 1'b0;
    end else if (en) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    div_stage_t nxt;
    always_comb begin
      nxt     = st_r[k-1];
      nxt.col = lane_step(st_r[k-1].col, st_r[k-1].den, QB - k);
      nxt.row = lane_step(st_r[k-1].row, st_r[k-1].den, QB - k);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].vld <= 1'b0;
      end else if (en) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign dout = st_r[QB];

endmodule

// ----- design/pcp_back.sv -----
// Back end: products, sums, divide, round and saturate
module pcp_back import pcp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  coef_t    coef,
  input  q_stat_t  q_stat,
  input  qitem_t   q_item,
  output logic     pop,
  pcp_out_if.source out_ch
);

  localparam int T_W = QS_W + 1;
  localparam logic signed [QS_W-1:0] Q_MAX =
    {{(QS_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [QS_W-1:0] Q_MIN =
    {{(QS_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [T_W-1:0] RND_HALF = T_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [T_W-1:0] PIX_TOP  = T_W'((1 << PIXEL_BITS) - 1);

  logic en;

  // stage 1: products
  logic                   s1_vld_r;
  logic                   s1_op_r;
  logic                   s1_fz_r;
  val_t                   s1_z_r;
  logic signed [P0_W-1:0] s1_px_r, s1_px_nxt;
  logic signed [P0_W-1:0] s1_py_r, s1_py_nxt;
  logic signed [PR_W-1:0] s1_pr_r [9];
  logic signed [PR_W-1:0] s1_pr_nxt [9];
  val_t                   pt [3];

  // stage 2: sums and operand select
  logic                    s2_vld_r;
  logic                    s2_op_r;
  logic                    s2_fz_r;
  val_t                    s2_z_r;
  logic signed [H_W-1:0]   h_sum [3];
  logic signed [NUM_W-1:0] s2_n0_r, s2_n0_nxt;
  logic signed [NUM_W-1:0] s2_n1_r, s2_n1_nxt;
  logic signed [DEN_W-1:0] s2_d_r, s2_d_nxt;

  // stage 3: magnitudes into divider
  div_stage_t s3_r, s3_nxt;
  div_stage_t dv;

  logic      out_vld_r;
  out_item_t out_r, out_nxt;

  assign en  = !out_vld_r || out_ch.ready;
  assign pop = en && !q_stat.empty;

  always_comb begin
    pt[0]     = q_item.in_x;
    pt[1]     = q_item.in_y;
    pt[2]     = q_item.in_z;
    s1_px_nxt = P0_W'($signed(q_item.depth)) * P0_W'($signed(q_item.dc));
    s1_py_nxt = P0_W'($signed(q_item.depth)) * P0_W'($signed(q_item.dr));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s1_pr_nxt[r*3+c] = PR_W'($signed(coef[r*4+c])) * PR_W'($signed(pt[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= pop;
      s1_op_r  <= q_item.op;
      s1_fz_r  <= q_item.f_zero;
      s1_z_r   <= q_item.depth;
      s1_px_r  <= s1_px_nxt;
      s1_py_r  <= s1_py_nxt;
      s1_pr_r  <= s1_pr_nxt;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      h_sum[r] = H_W'(s1_pr_r[r*3]) + H_W'(s1_pr_r[r*3+1]) + H_W'(s1_pr_r[r*3+2])
               + (H_W'($signed(coef[r*4+3])) <<< FRAC_BITS);
    end
    if (s1_op_r == OP_PROJECT) begin
      s2_n0_nxt = NUM_W'(h_sum[0]) <<< FRAC_BITS;
      s2_n1_nxt = NUM_W'(h_sum[1]) <<< FRAC_BITS;
      s2_d_nxt  = h_sum[2];
    end else begin
      s2_n0_nxt = NUM_W'(s1_px_r);
      s2_n1_nxt = NUM_W'(s1_py_r);
      s2_d_nxt  = DEN_W'($signed(coef[CF_FOCAL]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
      s2_op_r  <= s1_op_r;
      s2_fz_r  <= s1_fz_r;
      s2_z_r   <= s1_z_r;
      s2_n0_r  <= s2_n0_nxt;
      s2_n1_r  <= s2_n1_nxt;
      s2_d_r   <= s2_d_nxt;
    end
  end

  always_comb begin
    s3_nxt            = '0;
    s3_nxt.vld        = s2_vld_r;
    s3_nxt.side.op    = s2_op_r;
    s3_nxt.side.fault = (s2_op_r == OP_PROJECT) ? (s2_d_r == '0) : s2_fz_r;
    s3_nxt.side.z     = (s2_op_r == OP_BACKPROJ) ? s2_z_r : '0;
    s3_nxt.den        = s2_d_r[DEN_W-1] ? DM_W'(-s2_d_r) : DM_W'(s2_d_r);
    s3_nxt.col.rem    = s2_n0_r[NUM_W-1] ? NM_W'(-s2_n0_r) : NM_W'(s2_n0_r);
    s3_nxt.row.rem    = s2_n1_r[NUM_W-1] ? NM_W'(-s2_n1_r) : NM_W'(s2_n1_r);
    s3_nxt.col.neg    = s2_n0_r[NUM_W-1] ^ s2_d_r[DEN_W-1];
    s3_nxt.row.neg    = s2_n1_r[NUM_W-1] ^ s2_d_r[DEN_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
    end else if (en) begin
      s3_r <= s3_nxt;
    end
  end

  pcp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (s3_r),
    .dout  (dv)
  );

  // floor quotient from magnitude, sign and remainder
  function automatic logic signed [QS_W-1:0] q_signed(lane_t l);
    logic signed [QS_W-1:0] qe;
    qe = $signed(QS_W'(l.quo));
    if (l.neg) begin
      qe = (l.rem == '0) ? -qe : ~qe;
    end
    return qe;
  endfunction

  function automatic val_t sat_q(lane_t l);
    logic signed [QS_W-1:0] qs;
    val_t                   v;
    qs = q_signed(l);
    if (l.ovf) begin
      v = l.neg ? VAL_MIN : VAL_MAX;
    end else if (qs > Q_MAX) begin
      v = VAL_MAX;
    end else if (qs < Q_MIN) begin
      v = VAL_MIN;
    end else begin
      v = qs[VAL_W-1:0];
    end
    return v;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] rnd_q(lane_t l);
    logic signed [T_W-1:0]  t;
    logic [PIXEL_BITS-1:0]  p;
    t = (T_W'(q_signed(l)) + RND_HALF) >>> FRAC_BITS;
    if (l.ovf) begin
      p = l.neg ? '0 : '1;
    end else if (t < 0) begin
      p = '0;
    end else if (t > PIX_TOP) begin
      p = '1;
    end else begin
      p = t[PIXEL_BITS-1:0];
    end
    return p;
  endfunction

  always_comb begin
    out_nxt           = '0;
    out_nxt.div_fault = dv.side.fault;
    out_nxt.out_z     = dv.side.z;
    if (!dv.side.fault) begin
      if (dv.side.op == OP_BACKPROJ) begin
        out_nxt.out_x = sat_q(dv.col);
        out_nxt.out_y = sat_q(dv.row);
      end else begin
        out_nxt.plane_col = sat_q(dv.col);
        out_nxt.plane_row = sat_q(dv.row);
        out_nxt.round_col = rnd_q(dv.col);
        out_nxt.round_row = rnd_q(dv.row);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv.vld;
      out_r     <= out_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

endmodule

// ----- design/pinhole_camera_projection_unit.sv -----
// Top level of the pinhole camera projection unit
//
//  channel   direction  handshake          payload
//  in_ch     in         valid/ready        op, pixel, depth, point
//  out_ch    out        valid/ready        point, plane, pixels, fault
//  cfg (APB) in         psel/penable/...   six 64-bit matrix registers
//
// One request per cycle sustained while out_ch is not stalled; the back
// end registers products, sums, magnitudes, restoring divide and output.
// Reset is synchronous, active low: clears matrix registers, queue and
// stage valid bits. An output stall freezes the back pipeline; the
// four-entry queue keeps the front accepting until it fills.
`include "pinhole_camera_projection_unit_defines.svh"

module pinhole_camera_projection_unit import pcp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pcp_in_if.sink            in_ch,
  pcp_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready
);

  logic [REG_W-1:0]     cfg_r [NUM_REGS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  coef_t                coef;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  qitem_t  q_wdata;
  qitem_t  q_rdata;

  // byte address 8*i selects register i
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_wr && (reg_idx <= REG_ROW2_RIGHT)) begin
      cfg_r[reg_idx] <= pwdata;
    end
  end

  assign prdata = (reg_idx <= REG_ROW2_RIGHT) ? cfg_r[reg_idx] : '0;

  // low half is the first entry of each pair
  always_comb begin
    for (int k = 0; k < NUM_REGS; k++) begin
      coef[2*k]   = cfg_r[k][VAL_W-1:0];
      coef[2*k+1] = cfg_r[k][REG_W-1:VAL_W];
    end
  end

  pcp_front u_front (
    .in_ch  (in_ch),
    .coef   (coef),
    .q_stat (q_stat),
    .push   (q_push),
    .item   (q_wdata)
  );

  pcp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  pcp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .coef   (coef),
    .q_stat (q_stat),
    .q_item (q_rdata),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  `PCP_ASSERT_NOW(a_pop_nonempty, q_pop, !q_stat.empty)
  `PCP_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, q_stat.full)
  `PCP_ASSERT_NOW(a_fault_zeroes, out_ch.valid && out_ch.data.div_fault, out_ch.data.plane_col == '0 && out_ch.data.plane_row == '0 && out_ch.data.round_col == '0 && out_ch.data.round_row == '0)
  `PCP_ASSERT_NOW(a_op_exclusive, out_ch.valid && (out_ch.data.out_x != '0 || out_ch.data.out_y != '0), out_ch.data.plane_col == '0 && out_ch.data.plane_row == '0)

endmodule
